@@ design/cpwd_pkg.sv @@
`timescale 1ns / 1ps
// cpwd_pkg: shared types, default parameters and register codes for the
// pixel window core detector; no dependencies

package cpwd_pkg;

    // default build parameters
    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // fixed field widths of a result item
    localparam int ROW_W   = 16;
    localparam int COL_W   = 10;
    localparam int CNT_W   = 4;
    localparam int SCORE_W = 16;

    // register widths
    localparam int ATTR_W  = 16;
    localparam int CORE_W  = 4;
    localparam int MEAN_W  = 16;
    localparam int RCOLS_W = 11;
    localparam int RROWS_W = 16;

    // register reset values
    localparam logic [ATTR_W-1:0]         ATTR_RST  = '0;
    localparam logic [CORE_W-1:0]         CORE_RST  = CORE_W'(9);
    localparam logic signed [MEAN_W-1:0]  MEAN_RST  = '0;
    localparam logic [RCOLS_W-1:0]        RCOLS_RST = RCOLS_W'(1024);
    localparam logic [RROWS_W-1:0]        RROWS_RST = RROWS_W'(1024);

    // smallest raster edge the window supports
    localparam int MIN_EDGE = 3;

    // register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTR_THR  = 3'd0,
        CFG_CORE_THR  = 3'd1,
        CFG_MEAN      = 3'd2,
        CFG_COLUMNS   = 3'd3,
        CFG_ROWS      = 3'd4
    } t_cfg_idx;

    // one result item
    typedef struct packed {
        logic               center_valid;
        logic               is_core;
        logic [ROW_W-1:0]   center_row;
        logic [COL_W-1:0]   center_col;
        logic [CNT_W-1:0]   similar_count;
        logic [SCORE_W-1:0] score;
        logic               frame_last;
    } t_result;

endpackage

@@ design/cpwd_if.sv @@
`timescale 1ns / 1ps
// cpwd_if: valid/ready channels of the pixel window core detector
// (pixel items, result items, register writes); depends on cpwd_pkg

interface cpwd_pix_if #(
    parameter int SAMPLE_BITS = cpwd_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface cpwd_res_if;
    import cpwd_pkg::*;

    logic               valid;
    logic               ready;
    logic               center_valid;
    logic               is_core;
    logic [ROW_W-1:0]   center_row;
    logic [COL_W-1:0]   center_col;
    logic [CNT_W-1:0]   similar_count;
    logic [SCORE_W-1:0] score;
    logic               frame_last;

    modport source (output valid, output center_valid, output is_core, output center_row,
                    output center_col, output similar_count, output score,
                    output frame_last, input ready);
    modport sink   (input valid, input center_valid, input is_core, input center_row,
                    input center_col, input similar_count, input score,
                    input frame_last, output ready);
endinterface

interface cpwd_cfg_if;
    import cpwd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/core_pixel_window_detector.sv @@
`timescale 1ns / 1ps
// core_pixel_window_detector: streaming 3x3 core-pixel detector built around
// two line memories; depends on cpwd_pkg and the channels in cpwd_if

// Takes one pixel item per clock in raster order while the result side
// does not stall, and returns exactly one result item per pixel, in order.
// Each item passes the stage 1 registers and the window registers into the
// output register. Unstalled, the rate is one item per cycle. The two line
// memories are read at the column of the arriving pixel in the cycle it is
// taken. They are written back, shifted down one row, when that item moves
// on into the window, at the latest as the next pixel is taken. So every
// column is touched once per row and a read never meets a pending write to
// the same entry. The line memories hold no reset state;
// entries that were never written only reach windows that are not reported,
// so no clearing pass is needed and pixels are taken from the first cycle
// after reset. Register writes are taken every cycle and are meant to be
// issued while the block holds no pixel in flight.
module core_pixel_window_detector #(
    parameter int MAX_COLUMNS = cpwd_pkg::DEF_MAX_COLUMNS,
    parameter int SAMPLE_BITS = cpwd_pkg::DEF_SAMPLE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpwd_pix_if.sink    i_pix,
    cpwd_res_if.source  o_res,
    cpwd_cfg_if.sink    i_cfg
);
    import cpwd_pkg::*;

    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CMPW  = (CW + 1 > RCOLS_W) ? CW + 1 : RCOLS_W;
    localparam int COLXW = (CW > COL_W) ? CW : COL_W;
    localparam int DW    = SAMPLE_BITS + 1;
    localparam int TW    = (DW > ATTR_W) ? DW : ATTR_W;
    localparam int MW    = ((SAMPLE_BITS > MEAN_W) ? SAMPLE_BITS : MEAN_W) + 1;

    // configuration registers
    logic [ATTR_W-1:0]        r_attr_thr;
    logic [CORE_W-1:0]        r_core_thr;
    logic signed [MEAN_W-1:0] r_mean;
    logic [RCOLS_W-1:0]       r_cols;
    logic [RROWS_W-1:0]       r_rows;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_thr <= ATTR_RST;
            r_core_thr <= CORE_RST;
            r_mean     <= MEAN_RST;
            r_cols     <= RCOLS_RST;
            r_rows     <= RROWS_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_ATTR_THR: r_attr_thr <= i_cfg.data[ATTR_W-1:0];
                CFG_CORE_THR: r_core_thr <= i_cfg.data[CORE_W-1:0];
                CFG_MEAN:     r_mean     <= $signed(i_cfg.data[MEAN_W-1:0]);
                CFG_COLUMNS:  r_cols     <= i_cfg.data[RCOLS_W-1:0];
                CFG_ROWS:     r_rows     <= i_cfg.data[RROWS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline handshake: stage 1 memory read, stage 2 window, stage 3 result
    logic r_s1_v, r_s2_v, r_s3_v;
    logic take1, take2, take3, go1, go2, pix_acc;

    assign take3   = !r_s3_v || o_res.ready;
    assign go2     = r_s2_v && take3;
    assign take2   = !r_s2_v || take3;
    assign go1     = r_s1_v && take2;
    assign take1   = !r_s1_v || take2;
    assign i_pix.ready = take1;
    assign pix_acc = i_pix.valid && take1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (take1) r_s1_v <= i_pix.valid;
            if (take2) r_s2_v <= r_s1_v;
            if (take3) r_s3_v <= r_s2_v;
        end
    end

    // raster position and geometry clamps
    logic [CW-1:0]      r_col;
    logic [ROW_W-1:0]   r_row;
    logic [CMPW-1:0]    eff_cols;
    logic [RROWS_W-1:0] eff_rows;
    logic               row_end, frame_end, ctr_ok;
    logic [COLXW-1:0]   col_m1;

    always_comb begin
        if (r_cols < RCOLS_W'(MIN_EDGE)) begin
            eff_cols = CMPW'(MIN_EDGE);
        end else if (CMPW'(r_cols) > CMPW'(MAX_COLUMNS)) begin
            eff_cols = CMPW'(MAX_COLUMNS);
        end else begin
            eff_cols = CMPW'(r_cols);
        end
        eff_rows  = (r_rows < RROWS_W'(MIN_EDGE)) ? RROWS_W'(MIN_EDGE) : r_rows;
        row_end   = (CMPW'(r_col) + CMPW'(1)) >= eff_cols;
        frame_end = row_end && ((17'(r_row) + 17'd1) >= 17'(eff_rows));
        ctr_ok    = (r_row >= ROW_W'(2)) && (CMPW'(r_col) >= CMPW'(2));
        col_m1    = COLXW'(r_col) - COLXW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (pix_acc) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // line memories: a holds the row above, b two rows above
    logic signed [SAMPLE_BITS-1:0] r_line_a [MAX_COLUMNS];
    logic signed [SAMPLE_BITS-1:0] r_line_b [MAX_COLUMNS];
    logic signed [SAMPLE_BITS-1:0] r_top, r_mid;

    // stage 1 item data
    logic signed [SAMPLE_BITS-1:0] r_s1_px;
    logic [CW-1:0]                 r_s1_idx;
    logic                          r_s1_ok, r_s1_last;
    logic [ROW_W-1:0]              r_s1_row;
    logic [COL_W-1:0]              r_s1_col;

    // read on accept, registered data
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_top     <= r_line_b[r_col];
            r_mid     <= r_line_a[r_col];
            r_s1_px   <= i_pix.pixel_value;
            r_s1_idx  <= r_col;
            r_s1_ok   <= ctr_ok;
            r_s1_last <= frame_end;
            r_s1_row  <= r_row - ROW_W'(1);
            r_s1_col  <= col_m1[COL_W-1:0];
        end
    end

    // write back when the item moves into the window
    always_ff @(posedge i_clk) begin
        if (go1) begin
            r_line_b[r_s1_idx] <= r_mid;
            r_line_a[r_s1_idx] <= r_s1_px;
        end
    end

    // 3x3 window, column 2 is the newest
    logic signed [SAMPLE_BITS-1:0] r_win [9];
    logic                          r_s2_ok, r_s2_last;
    logic [ROW_W-1:0]              r_s2_row;
    logic [COL_W-1:0]              r_s2_col;

    always_ff @(posedge i_clk) begin
        if (go1) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2]  <= r_top;
            r_win[5]  <= r_mid;
            r_win[8]  <= r_s1_px;
            r_s2_ok   <= r_s1_ok;
            r_s2_last <= r_s1_last;
            r_s2_row  <= r_s1_row;
            r_s2_col  <= r_s1_col;
        end
    end

    // similarity count and score of the window center
    logic signed [DW-1:0]   diff [9];
    logic [DW-1:0]          mag  [9];
    logic [8:0]             sim;
    logic [CNT_W-1:0]       cnt;
    logic signed [MW-1:0]   sdiff;
    logic [MW-1:0]          smag;
    logic [SCORE_W-1:0]     score;
    t_result                n_res;

    always_comb begin
        cnt = CNT_W'(1);
        for (int k = 0; k < 9; k++) begin
            diff[k] = DW'(r_win[k]) - DW'(r_win[4]);
            mag[k]  = diff[k][DW-1] ? DW'(-diff[k]) : DW'(diff[k]);
            sim[k]  = (k != 4) && (TW'(mag[k]) < TW'(r_attr_thr));
            cnt     = cnt + CNT_W'(sim[k]);
        end
        sdiff = MW'(r_win[4]) - MW'(r_mean);
        smag  = sdiff[MW-1] ? MW'(-sdiff) : MW'(sdiff);
        score = (smag > MW'({SCORE_W{1'b1}})) ? {SCORE_W{1'b1}} : smag[SCORE_W-1:0];

        n_res            = '0;
        n_res.frame_last = r_s2_last;
        if (r_s2_ok) begin
            n_res.center_valid  = 1'b1;
            n_res.is_core       = cnt >= r_core_thr;
            n_res.center_row    = r_s2_row;
            n_res.center_col    = r_s2_col;
            n_res.similar_count = cnt;
            n_res.score         = score;
        end
    end

    // output register
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (go2) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid         = r_s3_v;
    assign o_res.center_valid  = r_res.center_valid;
    assign o_res.is_core       = r_res.is_core;
    assign o_res.center_row    = r_res.center_row;
    assign o_res.center_col    = r_res.center_col;
    assign o_res.similar_count = r_res.similar_count;
    assign o_res.score         = r_res.score;
    assign o_res.frame_last    = r_res.frame_last;

endmodule

@@ design/cpwd_checker.sv @@
`timescale 1ns / 1ps
// cpwd_checker: port-level assertions for core_pixel_window_detector and the
// bind that attaches them; depends on cpwd_pkg

module cpwd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         pix_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic                         res_center_valid,
    input logic                         res_is_core,
    input logic [cpwd_pkg::ROW_W-1:0]   res_center_row,
    input logic [cpwd_pkg::COL_W-1:0]   res_center_col,
    input logic [cpwd_pkg::CNT_W-1:0]   res_similar_count,
    input logic [cpwd_pkg::SCORE_W-1:0] res_score,
    input logic                         res_frame_last
);
    import cpwd_pkg::*;

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !res_valid)
        else $error("result item shown right after reset");

    // input backpressure only comes from a full, stalled result side
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!pix_ready) |-> (res_valid && !res_ready))
        else $error("pixel input stalled while result side can move");

    // a result without a center carries zero fields
    a_empty_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res_center_valid) |->
        (!res_is_core && res_center_row == '0 && res_center_col == '0 &&
         res_similar_count == '0 && res_score == '0))
        else $error("fields set on a result without a center");

    // a stalled result item holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res_ready) |=>
        (res_valid && $stable(res_center_valid) && $stable(res_is_core) &&
         $stable(res_center_row) && $stable(res_center_col) &&
         $stable(res_similar_count) && $stable(res_score) && $stable(res_frame_last)))
        else $error("stalled result item changed");

endmodule

bind core_pixel_window_detector cpwd_checker u_cpwd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .pix_ready         (i_pix.ready),
    .res_valid         (o_res.valid),
    .res_ready         (o_res.ready),
    .res_center_valid  (o_res.center_valid),
    .res_is_core       (o_res.is_core),
    .res_center_row    (o_res.center_row),
    .res_center_col    (o_res.center_col),
    .res_similar_count (o_res.similar_count),
    .res_score         (o_res.score),
    .res_frame_last    (o_res.frame_last)
);
